FILE: rtl/cdc_pkg.sv
// Shared types, constants and calendar tables for the day count block.
package cdc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ORD_W   = 22;
    localparam int COUNT_W = 22;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2**15
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [6:0]  CENTURY     = 7'd100;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    // Stage load enables handed to each date unit.
    typedef struct packed {
        logic en_a;
        logic en_b;
    } cdc_pipe_t;

    // Month length; zero for month codes that mean nothing.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of month m.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] cum;
        case (m)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

FILE: rtl/cdc_ordinal.sv
// Two-stage date unit: validity check and day ordinal of one Gregorian date.
module cdc_ordinal (
    input  logic                            aclk,
    input  cdc_pkg::cdc_pipe_t              pipe,
    input  logic [cdc_pkg::YEAR_W-1:0]      year,
    input  logic [cdc_pkg::MONTH_W-1:0]     month,
    input  logic [cdc_pkg::DAY_W-1:0]       day,
    output logic [cdc_pkg::ORD_W-1:0]       ordinal,
    output logic                            date_ok
);

    // stage A: products
    logic [cdc_pkg::YEAR_W-1:0]  year_a_reg;
    logic [cdc_pkg::MONTH_W-1:0] month_a_reg;
    logic [cdc_pkg::DAY_W-1:0]   day_a_reg;
    logic [7:0]                  qfloor_a_reg;
    logic [8:0]                  qceil_a_reg;
    logic [22:0]                 y365_a_reg;
    logic                        big_a_reg;

    logic [26:0] prod_floor;
    logic [14:0] year_p99;
    logic [27:0] prod_ceil;

    assign prod_floor = 27'(year) * 27'(cdc_pkg::RECIP_100);
    assign year_p99   = 15'(year) + 15'd99;
    assign prod_ceil  = 28'(year_p99) * 28'(cdc_pkg::RECIP_100);

    always_ff @(posedge aclk) begin
        if (pipe.en_a) begin
            year_a_reg   <= year;
            month_a_reg  <= month;
            day_a_reg    <= day;
            qfloor_a_reg <= prod_floor[cdc_pkg::RECIP_SHIFT +: 8];
            qceil_a_reg  <= prod_ceil[cdc_pkg::RECIP_SHIFT +: 9];
            y365_a_reg   <= 23'(year) * 23'(cdc_pkg::DAYS_YEAR);
            big_a_reg    <= year > cdc_pkg::YEAR_MAX;
        end
    end

    // stage B: leap rule, ordinal, range check
    logic [14:0]              rem_year;
    logic                     leap;
    logic [14:0]              year_p3;
    logic [12:0]              leaps_before;
    logic [9:0]               qceil_p3;
    logic [cdc_pkg::DAY_W-1:0] len;
    logic [22:0]              ord_sum;
    logic                     ok_next;
    logic [cdc_pkg::ORD_W-1:0] ord_reg;
    logic                     ok_reg;

    assign rem_year = 15'(year_a_reg) - 15'(qfloor_a_reg) * 15'(cdc_pkg::CENTURY);
    assign leap     = (year_a_reg[1:0] == 2'd0) &&
                      ((rem_year != 15'd0) || (qfloor_a_reg[1:0] == 2'd0));

    // leap years before this one: ceil(y/4) - ceil(y/100) + ceil(y/400)
    assign year_p3      = 15'(year_a_reg) + 15'd3;
    assign qceil_p3     = 10'(qceil_a_reg) + 10'd3;
    assign leaps_before = year_p3[14:2] - 13'(qceil_a_reg) + 13'(qceil_p3[9:2]);

    assign len     = cdc_pkg::month_len(month_a_reg, leap);
    assign ok_next = !big_a_reg && (day_a_reg != '0) && (day_a_reg <= len);

    assign ord_sum = y365_a_reg + 23'(leaps_before)
                   + 23'(cdc_pkg::days_before(month_a_reg))
                   + 23'(leap && (month_a_reg > cdc_pkg::MONTH_FEB))
                   + 23'(day_a_reg);

    always_ff @(posedge aclk) begin
        if (pipe.en_b) begin
            ord_reg <= ord_sum[cdc_pkg::ORD_W-1:0];
            ok_reg  <= ok_next;
        end
    end

    assign ordinal = ord_reg;
    assign date_ok = ok_reg;

endmodule

FILE: rtl/calendar_day_count.sv
// Top level: inclusive day count between two Gregorian dates.
//
// Each item on the s_ channel carries two dates; each item on the m_ channel
// carries the inclusive count of days between them (1 for equal dates) and,
// on m_tuser, a flag for a bad year, month or day, in which case the count
// is 0. The order of the two dates does not matter.
//
// Items move through four register stages: input register, product stage,
// ordinal stage and result register. The edge that accepts an item loads the
// input register, and the result register drives m_tvalid. One item is
// accepted per cycle while the output is not stalled, since every stage is
// one pass of constant multiplies and adds.
//
// Each stage holds its item while the stage ahead is full and stalled;
// s_tready falls only once all four stages hold items and m_tready is low. A stalled result
// stays on m_tdata and m_tuser unchanged.
//
// Reset (aresetn low at a clock edge) empties every stage; payload registers
// keep stale values that are never shown.
module calendar_day_count (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_year, first_month, first_day, second_year, second_month,
    // second_day, zero fill
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_count, zero fill
    output logic [23:0] m_tdata,
    // date_invalid
    output logic        m_tuser
);

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || m_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign s_tready = rdy0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // input register
    logic [45:0] in_reg;

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            in_reg <= s_tdata[45:0];
        end
    end

    cdc_pkg::cdc_pipe_t pipe;
    assign pipe.en_a = rdy1;
    assign pipe.en_b = rdy2;

    logic [cdc_pkg::ORD_W-1:0] ord_first, ord_second;
    logic                      ok_first, ok_second;

    cdc_ordinal u_first (
        .aclk    (aclk),
        .pipe    (pipe),
        .year    (in_reg[13:0]),
        .month   (in_reg[17:14]),
        .day     (in_reg[22:18]),
        .ordinal (ord_first),
        .date_ok (ok_first)
    );

    cdc_ordinal u_second (
        .aclk    (aclk),
        .pipe    (pipe),
        .year    (in_reg[36:23]),
        .month   (in_reg[40:37]),
        .day     (in_reg[45:41]),
        .ordinal (ord_second),
        .date_ok (ok_second)
    );

    // result register
    logic [cdc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        invalid_reg, invalid_next;
    logic [cdc_pkg::ORD_W-1:0]   diff;

    always_comb begin
        diff         = (ord_first > ord_second) ? ord_first - ord_second
                                                : ord_second - ord_first;
        invalid_next = !(ok_first && ok_second);
        count_next   = invalid_next ? '0 : cdc_pkg::COUNT_W'(diff) + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            count_reg   <= count_next;
            invalid_reg <= invalid_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {2'b00, count_reg};
    assign m_tuser  = invalid_reg;

endmodule

FILE: rtl/cdc_checker.sv
// Port-level checker for the day count block, bound to the top level.
module cdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an invalid item always reports a zero count
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[21:0] == 22'd0)
        else $error("invalid item with nonzero count");

    // a valid item always counts at least one day and fits its field
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[21:0] != 22'd0) && (m_tdata[23:22] == 2'b00))
        else $error("valid item with bad count");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a ready receiver never blocks the input
    a_ready_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while receiver ready");

endmodule

bind calendar_day_count cdc_checker u_cdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
